/* hw/rtl/ile_pkg.sv */
// Shared types and constants for the indexed list engine.
// No dependencies; imported by ile_max_unit and indexed_list_engine_unit.
`default_nettype none

package ile_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int LEN_W  = 9;

  // Operation codes carried in a request.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MOVE   = 2'd2,
    OP_READ   = 2'd3
  } ile_op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CAPT,
    S_SHIFT,
    S_SCAN,
    S_DONE
  } ile_state_t;

  // One request.
  typedef struct packed {
    ile_op_t                   operation;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } ile_req_t;

  // One result.
  typedef struct packed {
    logic signed [DATA_W-1:0]  read_value;
    logic                      read_valid;
    logic [LEN_W-1:0]          list_length;
    logic signed [DATA_W-1:0]  max_value;
    logic                      max_valid;
    logic                      op_error;
  } ile_rsp_t;

  // Controls from the sequencer to the maximum tracker.
  typedef struct packed {
    logic clear;
    logic start;
    logic sample;
  } ile_max_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/ile_max_unit.sv */
// Running maximum tracker: one signed comparator reused for every scanned entry.
// Depends on ile_pkg for the control struct and data width.
`default_nettype none

module ile_max_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  ile_pkg::ile_max_ctl_t             ctl,
  input  logic signed [ile_pkg::DATA_W-1:0] data,
  output logic signed [ile_pkg::DATA_W-1:0] max_value,
  output logic                              max_valid
);
  import ile_pkg::*;

  logic first;

  // The first sample of a scan loads unconditionally; later ones keep the larger value.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_value <= '0;
      max_valid <= 1'b0;
      first     <= 1'b0;
    end else if (ctl.clear) begin
      max_value <= '0;
      max_valid <= 1'b0;
      first     <= 1'b0;
    end else if (ctl.start) begin
      first <= 1'b1;
    end else if (ctl.sample) begin
      if (first || (data > max_value)) begin
        max_value <= data;
      end
      first     <= 1'b0;
      max_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/indexed_list_engine_unit.sv */
// Indexed list engine: ordered list of signed 32-bit values in an on-chip store.
// Depends on ile_pkg and ile_max_unit.
//
// Usage:
//   A request (req_valid/req_ready/req_data) carries an operation, a position
//   and a value: insert at a position, remove, move to end, or read. Each request
//   yields exactly one response (rsp_valid/rsp_ready/rsp_data) with the read
//   value, list length, list maximum and an error flag.
//   The block works on one request at a time; req_ready is high only while idle.
//   A read fetches and captures the addressed entry, then answers. Insert, remove
//   and move shift the later entries through the single-port-pair store at one
//   entry per cycle, then rescan every stored entry at one per cycle through one
//   shared comparator; a move also fetches its entry first. Rejected requests go
//   straight to the response state. The next request is accepted in the cycle
//   after a response is loaded.
//   A response sits in an output register, so the next request is accepted while
//   it waits; if the receiver stalls, the following response is held back until
//   the register frees.
//   Reset empties the list at once; store contents are never cleared, since only
//   entries below the length are ever read.
`default_nettype none

module indexed_list_engine_unit #(
  parameter int CAPACITY = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  ile_pkg::ile_req_t req_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output ile_pkg::ile_rsp_t rsp_data
);
  import ile_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Entry store and its registered read port.
  logic [DATA_W-1:0] mem [CAPACITY];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] rdata;

  // Sequencer registers.
  ile_state_t        state, state_next;
  ile_op_t           op, op_next;
  logic [CW-1:0]     pos, pos_next;
  logic [DATA_W-1:0] val, val_next;
  logic [DATA_W-1:0] held, held_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     cur, cur_next;
  logic [CW-1:0]     left, left_next;
  logic              pv, pv_next;
  logic [AW-1:0]     pwaddr, pwaddr_next;
  logic              err, err_next;
  logic              rd_ok, rd_ok_next;

  logic              rsp_load;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     cnt_x;

  ile_max_ctl_t              mctl;
  logic signed [DATA_W-1:0]  max_value_i;
  logic                      max_valid_i;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Shared maximum comparator.
  ile_max_unit u_max (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mctl),
    .data      ($signed(rdata)),
    .max_value (max_value_i),
    .max_valid (max_valid_i)
  );

  assign pos_x = XW'(req_data.position);
  assign cnt_x = XW'(count);

  // Sequencer state and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pv    <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pv    <= pv_next;
    end
    op     <= op_next;
    pos    <= pos_next;
    val    <= val_next;
    held   <= held_next;
    cur    <= cur_next;
    left   <= left_next;
    pwaddr <= pwaddr_next;
    err    <= err_next;
    rd_ok  <= rd_ok_next;
  end

  // Next state, store accesses and comparator controls.
  always_comb begin
    state_next  = state;
    op_next     = op;
    pos_next    = pos;
    val_next    = val;
    held_next   = held;
    count_next  = count;
    cur_next    = cur;
    left_next   = left;
    pv_next     = 1'b0;
    pwaddr_next = pwaddr;
    err_next    = err;
    rd_ok_next  = rd_ok;
    mem_we      = 1'b0;
    mem_waddr   = pwaddr;
    mem_wdata   = rdata;
    mem_re      = 1'b0;
    mem_raddr   = cur[AW-1:0];
    mctl        = '0;
    req_ready   = 1'b0;
    rsp_load    = 1'b0;

    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_next    = req_data.operation;
          pos_next   = pos_x[CW-1:0];
          val_next   = req_data.value;
          err_next   = 1'b0;
          rd_ok_next = 1'b0;
          case (req_data.operation)
            OP_INSERT: begin
              if ((pos_x > cnt_x) || (count == CAP_C)) begin
                err_next   = 1'b1;
                state_next = S_DONE;
              end else begin
                cur_next   = count - CW'(1);
                left_next  = count - pos_x[CW-1:0];
                state_next = S_SHIFT;
              end
            end
            OP_REMOVE: begin
              if (pos_x >= cnt_x) begin
                err_next   = 1'b1;
                state_next = S_DONE;
              end else begin
                cur_next   = pos_x[CW-1:0] + CW'(1);
                left_next  = count - pos_x[CW-1:0] - CW'(1);
                state_next = S_SHIFT;
              end
            end
            default: begin
              // Move and read both start by fetching the addressed entry.
              if (pos_x >= cnt_x) begin
                err_next   = 1'b1;
                state_next = S_DONE;
              end else begin
                state_next = S_FETCH;
              end
            end
          endcase
        end
      end

      S_FETCH: begin
        mem_re     = 1'b1;
        mem_raddr  = pos[AW-1:0];
        state_next = S_CAPT;
      end

      S_CAPT: begin
        held_next = rdata;
        if (op == OP_READ) begin
          rd_ok_next = 1'b1;
          state_next = S_DONE;
        end else begin
          cur_next   = pos + CW'(1);
          left_next  = count - pos - CW'(1);
          state_next = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // Write back the entry read in the previous cycle one place over.
        if (pv) begin
          mem_we    = 1'b1;
          mem_waddr = pwaddr;
          mem_wdata = rdata;
        end
        if (left != '0) begin
          mem_re    = 1'b1;
          mem_raddr = cur[AW-1:0];
          pv_next   = 1'b1;
          left_next = left - CW'(1);
          if (op == OP_INSERT) begin
            pwaddr_next = AW'(cur + CW'(1));
            cur_next    = cur - CW'(1);
          end else begin
            pwaddr_next = AW'(cur - CW'(1));
            cur_next    = cur + CW'(1);
          end
        end else if (!pv) begin
          // Shifting done: place the new or moved entry, then rescan unless the list emptied.
          cur_next   = '0;
          left_next  = count;
          mctl.start = 1'b1;
          state_next = S_SCAN;
          case (op)
            OP_INSERT: begin
              mem_we     = 1'b1;
              mem_waddr  = pos[AW-1:0];
              mem_wdata  = val;
              count_next = count + CW'(1);
              left_next  = count + CW'(1);
            end
            OP_REMOVE: begin
              count_next = count - CW'(1);
              left_next  = count - CW'(1);
              if (count == CW'(1)) begin
                mctl.start = 1'b0;
                mctl.clear = 1'b1;
                state_next = S_DONE;
              end
            end
            default: begin
              mem_we    = 1'b1;
              mem_waddr = AW'(count - CW'(1));
              mem_wdata = held;
            end
          endcase
        end
      end

      S_SCAN: begin
        // One entry read per cycle; the comparator samples the registered read data in the next cycle.
        if (pv) begin
          mctl.sample = 1'b1;
        end
        if (left != '0) begin
          mem_re    = 1'b1;
          mem_raddr = cur[AW-1:0];
          pv_next   = 1'b1;
          cur_next  = cur + CW'(1);
          left_next = left - CW'(1);
        end else if (!pv) begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (rsp_load) begin
      rsp_data.read_value  <= rd_ok ? $signed(held) : '0;
      rsp_data.read_valid  <= rd_ok;
      rsp_data.list_length <= LEN_W'(count);
      rsp_data.max_value   <= max_value_i;
      rsp_data.max_valid   <= max_valid_i;
      rsp_data.op_error    <= err;
    end
  end

  // The length never passes the store size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("entry count exceeds capacity");

  // A pending read result only exists while shifting or scanning.
  a_pend_state: assert property (@(posedge clk) disable iff (rst)
    pv |-> (state == S_SHIFT || state == S_SCAN))
    else $error("pending read outside shift or scan");

  // Between requests the maximum flag agrees with the list being non-empty.
  a_max_tracks: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (max_valid_i == (count != '0)))
    else $error("maximum flag out of step with list length");

  // A rejected request leaves the length alone.
  a_error_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && err) |-> (count == $past(count)))
    else $error("rejected request changed the length");

  // A successful read is never flagged as an error.
  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.read_valid) |-> !rsp_data.op_error)
    else $error("read response both valid and in error");

endmodule

`default_nettype wire
